[sv/aabb_collision_resolve_macros.svh]
// Assertion macros for the AABB collision resolver.
// Included by the top level; depends on nothing else.
`ifndef AABB_COLLISION_RESOLVE_MACROS_SVH
`define AABB_COLLISION_RESOLVE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aabb_collision_resolve: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aabb_collision_resolve: next-cycle check failed");

`endif

[sv/acr_pkg.sv]
// Shared types and constants for the AABB collision resolver.
// Used by acr_cfg_regs, acr_resolve and aabb_collision_resolve; no dependencies.
`default_nettype none

package acr_pkg;

    localparam int POS_W  = 24;
    localparam int SIZE_W = 20;
    // Working width: every sum and difference of positions, offsets and
    // sizes fits in 27 signed bits; one spare bit keeps differences exact.
    localparam int WIDE_W = 28;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic        [SIZE_W-1:0] t_size;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_OFFSET_X = 2'd0;
    localparam t_cfg_idx REG_OFFSET_Y = 2'd1;
    localparam t_cfg_idx REG_WIDTH    = 2'd2;
    localparam t_cfg_idx REG_HEIGHT   = 2'd3;

    localparam t_pos  RST_OFFSET = 24'sd0;
    localparam t_size RST_SIZE   = 20'd4096;

    localparam t_pos POS_MAX = 24'sh7FFFFF;
    localparam t_pos POS_MIN = 24'sh800000;
    localparam t_pos POS_ZERO = 24'sd0;

    typedef struct packed {
        t_pos  offset_x;
        t_pos  offset_y;
        t_size width;
        t_size height;
    } t_cfg;

    typedef struct packed {
        t_pos  pos_x;
        t_pos  pos_y;
        t_pos  prev_x;
        t_pos  prev_y;
        t_pos  vel_x;
        t_pos  vel_y;
        t_pos  obstacle_left;
        t_pos  obstacle_top;
        t_size obstacle_width;
        t_size obstacle_height;
    } t_item;

    typedef struct packed {
        logic collided;
        logic grounded;
        t_pos new_pos_x;
        t_pos new_pos_y;
        t_pos new_vel_x;
        t_pos new_vel_y;
    } t_result;

    function automatic t_wide wide_s(input t_pos v);
        return {{(WIDE_W-POS_W){v[POS_W-1]}}, v};
    endfunction

    function automatic t_wide wide_u(input t_size v);
        return {{(WIDE_W-SIZE_W){1'b0}}, v};
    endfunction

    function automatic t_wide max_w(input t_wide a, input t_wide b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_wide min_w(input t_wide a, input t_wide b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pos sat_pos(input t_wide v);
        if (v > wide_s(POS_MAX)) begin
            return POS_MAX;
        end else if (v < wide_s(POS_MIN)) begin
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/acr_cfg_regs.sv]
// Hitbox configuration registers (offsets and size) for the collision resolver.
// Depends on acr_pkg.
`default_nettype none

module acr_cfg_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire acr_pkg::t_cfg_idx i_index,
    input  wire acr_pkg::t_pos     i_wdata,
    output acr_pkg::t_cfg          o_cfg
);

    acr_pkg::t_cfg r_cfg;
    acr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_index)
                acr_pkg::REG_OFFSET_X: n_cfg.offset_x = i_wdata;
                acr_pkg::REG_OFFSET_Y: n_cfg.offset_y = i_wdata;
                acr_pkg::REG_WIDTH:    n_cfg.width    = i_wdata[acr_pkg::SIZE_W-1:0];
                acr_pkg::REG_HEIGHT:   n_cfg.height   = i_wdata[acr_pkg::SIZE_W-1:0];
                default:               n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x <= acr_pkg::RST_OFFSET;
            r_cfg.offset_y <= acr_pkg::RST_OFFSET;
            r_cfg.width    <= acr_pkg::RST_SIZE;
            r_cfg.height   <= acr_pkg::RST_SIZE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/acr_resolve.sv]
// Combinational overlap test and side resolution for one box pair.
// Depends on acr_pkg.
`default_nettype none

module acr_resolve (
    input  wire acr_pkg::t_cfg  i_cfg,
    input  wire acr_pkg::t_item i_item,
    output acr_pkg::t_result    o_result
);

    acr_pkg::t_wide off_x, off_y, box_w, box_h;
    acr_pkg::t_wide ml, mt, mr, mb, sl, st, sr, sb;
    acr_pkg::t_wide p_top, p_bot, p_left, p_right;
    acr_pkg::t_wide y_land, y_below, x_lefts, x_rights;
    acr_pkg::t_wide ov_v, ov_h;
    acr_pkg::t_wide nx, ny;
    logic           overlap, down, right;

    always_comb begin
        off_x = acr_pkg::wide_s(i_cfg.offset_x);
        off_y = acr_pkg::wide_s(i_cfg.offset_y);
        box_w = acr_pkg::wide_u(i_cfg.width);
        box_h = acr_pkg::wide_u(i_cfg.height);

        // Current hitbox and static box edges
        ml = acr_pkg::wide_s(i_item.pos_x) + off_x;
        mt = acr_pkg::wide_s(i_item.pos_y) + off_y;
        mr = ml + box_w;
        mb = mt + box_h;
        sl = acr_pkg::wide_s(i_item.obstacle_left);
        st = acr_pkg::wide_s(i_item.obstacle_top);
        sr = sl + acr_pkg::wide_u(i_item.obstacle_width);
        sb = st + acr_pkg::wide_u(i_item.obstacle_height);

        overlap = (acr_pkg::max_w(ml, sl) < acr_pkg::min_w(mr, sr)) &&
                  (acr_pkg::max_w(mt, st) < acr_pkg::min_w(mb, sb));

        // Hitbox edges at the previous position
        p_top   = acr_pkg::wide_s(i_item.prev_y) + off_y;
        p_bot   = p_top + box_h;
        p_left  = acr_pkg::wide_s(i_item.prev_x) + off_x;
        p_right = p_left + box_w;

        // Entity positions that put the hitbox flush against each edge
        y_land   = st - off_y - box_h;
        y_below  = sb - off_y;
        x_lefts  = sl - off_x - box_w;
        x_rights = sr - off_x;

        ov_v = acr_pkg::min_w(mb, sb) - acr_pkg::max_w(mt, st);
        ov_h = acr_pkg::min_w(mr, sr) - acr_pkg::max_w(ml, sl);

        down  = !i_item.vel_y[acr_pkg::POS_W-1];
        right = !i_item.vel_x[acr_pkg::POS_W-1];

        nx = acr_pkg::wide_s(i_item.pos_x);
        ny = acr_pkg::wide_s(i_item.pos_y);
        o_result.collided  = overlap;
        o_result.grounded  = 1'b0;
        o_result.new_vel_x = i_item.vel_x;
        o_result.new_vel_y = i_item.vel_y;

        if (overlap) begin
            if (p_bot <= st && down) begin
                ny = y_land;
                o_result.new_vel_y = acr_pkg::POS_ZERO;
                o_result.grounded  = 1'b1;
            end else if (p_top >= sb && !down) begin
                ny = y_below;
                o_result.new_vel_y = acr_pkg::POS_ZERO;
            end else if (p_right <= sl) begin
                nx = x_lefts;
                o_result.new_vel_x = acr_pkg::POS_ZERO;
            end else if (p_left >= sr) begin
                nx = x_rights;
                o_result.new_vel_x = acr_pkg::POS_ZERO;
            end else if (ov_v < ov_h) begin
                ny = down ? y_land : y_below;
                o_result.new_vel_y = acr_pkg::POS_ZERO;
                o_result.grounded  = down;
            end else begin
                nx = right ? x_lefts : x_rights;
                o_result.new_vel_x = acr_pkg::POS_ZERO;
            end
        end

        o_result.new_pos_x = acr_pkg::sat_pos(nx);
        o_result.new_pos_y = acr_pkg::sat_pos(ny);
    end

endmodule

`default_nettype wire

[sv/aabb_collision_resolve.sv]
// Top level of the 2D AABB collision resolver: handshake pipeline and result register.
// Depends on acr_pkg, acr_cfg_regs, acr_resolve and aabb_collision_resolve_macros.svh.
//
// This block resolves one moving axis-aligned box against one static box per
// transaction. Each transaction passes through the input register and then the
// result register, and its result is held until the result side takes it. A
// new transaction may be accepted on every cycle while the result side keeps
// taking results, so the sustained rate is then one box pair per clock. The
// overlap test, side selection, snap and saturation sit between the input
// register and the result register as one pass of adders, comparators and
// multiplexers. Each register stage stalls only when it is full and the stage
// after it cannot take its contents, so a held result never prevents the
// input register from filling. The moving hitbox offset and size come from
// four configuration registers (offset x, offset y, width, height), written
// through the plain write port and reset to zero offsets and a 16.0 by 16.0
// box; they should only be changed while no transaction is in flight.
// Positions, offsets and velocities are signed Q15.8, sizes unsigned Q12.8,
// and resolved positions saturate to 24 bits.
`default_nettype none

`include "aabb_collision_resolve_macros.svh"

module aabb_collision_resolve (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_we,
    input  wire acr_pkg::t_cfg_idx    i_cfg_index,
    input  wire acr_pkg::t_pos        i_cfg_wdata,

    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire acr_pkg::t_pos        i_pos_x,
    input  wire acr_pkg::t_pos        i_pos_y,
    input  wire acr_pkg::t_pos        i_prev_x,
    input  wire acr_pkg::t_pos        i_prev_y,
    input  wire acr_pkg::t_pos        i_vel_x,
    input  wire acr_pkg::t_pos        i_vel_y,
    input  wire acr_pkg::t_pos        i_obstacle_left,
    input  wire acr_pkg::t_pos        i_obstacle_top,
    input  wire acr_pkg::t_size       i_obstacle_width,
    input  wire acr_pkg::t_size       i_obstacle_height,

    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_collided,
    output logic                      o_grounded,
    output acr_pkg::t_pos             o_new_pos_x,
    output acr_pkg::t_pos             o_new_pos_y,
    output acr_pkg::t_pos             o_new_vel_x,
    output acr_pkg::t_pos             o_new_vel_y
);

    acr_pkg::t_cfg    cfg;
    acr_pkg::t_item   in_item;
    acr_pkg::t_result res;

    logic             r_s1_valid;
    acr_pkg::t_item   r_s1_item;
    logic             r_s2_valid;
    acr_pkg::t_result r_s2_res;

    logic             s1_ready;
    logic             s2_ready;
    logic             push_axis_clear;

    acr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    always_comb begin
        in_item.pos_x           = i_pos_x;
        in_item.pos_y           = i_pos_y;
        in_item.prev_x          = i_prev_x;
        in_item.prev_y          = i_prev_y;
        in_item.vel_x           = i_vel_x;
        in_item.vel_y           = i_vel_y;
        in_item.obstacle_left   = i_obstacle_left;
        in_item.obstacle_top    = i_obstacle_top;
        in_item.obstacle_width  = i_obstacle_width;
        in_item.obstacle_height = i_obstacle_height;
    end

    // A stage can load when it is empty or its contents move on this cycle.
    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_item <= in_item;
        end
    end

    acr_resolve u_resolve (
        .i_cfg    (cfg),
        .i_item   (r_s1_item),
        .o_result (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_res <= res;
        end
    end

    assign o_valid     = r_s2_valid;
    assign o_collided  = r_s2_res.collided;
    assign o_grounded  = r_s2_res.grounded;
    assign o_new_pos_x = r_s2_res.new_pos_x;
    assign o_new_pos_y = r_s2_res.new_pos_y;
    assign o_new_vel_x = r_s2_res.new_vel_x;
    assign o_new_vel_y = r_s2_res.new_vel_y;

    // At least one velocity component of the presented result is zero.
    assign push_axis_clear = (o_new_vel_x == acr_pkg::POS_ZERO) ||
                             (o_new_vel_y == acr_pkg::POS_ZERO);

    // Landing on top is only ever reported as part of a collision.
    `ACR_ASSERT_NOW(a_grounded_needs_hit, i_clk, i_rst_n, o_valid && o_grounded, o_collided)
    // A resolved collision always clears the velocity on the push axis.
    `ACR_ASSERT_NOW(a_hit_clears_axis, i_clk, i_rst_n, o_valid && o_collided, push_axis_clear)
    // An accepted transaction lands in the input register.
    `ACR_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, i_valid && o_ready, r_s1_valid)
    // A transaction in the input register moves to the result register when it is free.
    `ACR_ASSERT_NEXT(a_s1_moves_on, i_clk, i_rst_n, r_s1_valid && s2_ready, o_valid)

endmodule

`default_nettype wire
